FILE: src/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an implication holds in the next cycle, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/fsse_pkg.sv
// Package for the float sample saturating encoder: types, codes, constants.
// Depends on nothing.
package fsse_pkg;

  localparam int unsigned WidthW = 7;
  localparam int unsigned KindW = 3;
  localparam int unsigned AddrW = 3;

  localparam logic [WidthW-1:0] WidthReset = 7'd8;
  localparam logic [KindW-1:0] KindReset = 3'd1;

  localparam logic [KindW-1:0] KindSigned = 3'd2;
  localparam logic [KindW-1:0] KindFloat = 3'd3;

  localparam logic [AddrW-1:0] AddrWidth = 3'd0;
  localparam logic [AddrW-1:0] AddrKind = 3'd4;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StHalf = 2'd1,
    StWidth = 2'd2
  } status_t;

  // Target format decoded from the registers.
  typedef enum logic [1:0] {
    FmtInt8 = 2'd0,
    FmtInt16 = 2'd1,
    FmtInt32 = 2'd2,
    FmtPass = 2'd3
  } fmt_t;

  // Word after float decode.
  typedef struct packed {
    logic        is_neg;
    logic        is_zero;   // zero, NaN or below one in magnitude
    logic        is_big;    // magnitude at least 2^32 or infinite
    logic [4:0]  shift;     // integer exponent 0..31
    logic [23:0] mant;      // with hidden bit
  } dec_t;

endpackage

FILE: src/float_sample_saturating_encoder_top.sv
// Top level of the float sample saturating encoder.
// Depends on fsse_pkg, fsse_decode, fsse_shift, fsse_clamp, assert_macros.svh.
//
// Converts one single-precision sample per clock, while the output is taken,
// into an 8, 16 or 32 bit integer (saturated, truncated toward zero, NaN as
// zero) or passes the float through. A word passes three register stages
// (decode, shift, saturate); its result is held in the saturate register. The
// pipeline accepts a new word every cycle and stalls as a whole when the
// output word is not taken. Registers: width at byte address 0, format at 4
// (the low two address bits are ignored); write them only while the pipeline
// is empty.
module float_sample_saturating_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] float_bits,
  input  logic        row_end_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] encoded_sample,
  output logic [1:0]  encode_status,
  output logic        row_end_out
);

`include "assert_macros.svh"

  logic [6:0] sample_width;
  logic [2:0] sample_kind;
  logic [2:0] word_addr;
  logic [2:0] vld;
  logic       advance;
  logic [31:0] raw1, raw2;
  logic [2:0] row;
  logic [1:0] st1, st2, st3;
  fsse_pkg::fmt_t fmt;
  fsse_pkg::status_t status;
  fsse_pkg::dec_t dec;
  logic [31:0] mag;
  logic neg, big;
  logic [31:0] enc;

  // Register port, decoded on word addresses.
  assign pready = 1'b1;
  assign word_addr = {paddr[2], 2'b00};
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_width <= fsse_pkg::WidthReset;
      sample_kind <= fsse_pkg::KindReset;
    end else if (psel && penable && pwrite) begin
      if (word_addr == fsse_pkg::AddrWidth) sample_width <= pwdata[6:0];
      else if (word_addr == fsse_pkg::AddrKind) sample_kind <= pwdata[2:0];
    end
  end

  always_comb begin
    if (word_addr == fsse_pkg::AddrWidth) prdata = {25'd0, sample_width};
    else if (word_addr == fsse_pkg::AddrKind) prdata = {29'd0, sample_kind};
    else prdata = 32'd0;
  end

  // Decode the format from the registers.
  always_comb begin
    fmt = fsse_pkg::FmtInt8;
    status = fsse_pkg::StOk;
    priority if (sample_width == 7'd8) begin
      fmt = fsse_pkg::FmtInt8;
    end else if (sample_width == 7'd16) begin
      fmt = fsse_pkg::FmtInt16;
      if (sample_kind == fsse_pkg::KindFloat) status = fsse_pkg::StHalf;
    end else if (sample_width == 7'd32) begin
      fmt = (sample_kind == fsse_pkg::KindFloat) ? fsse_pkg::FmtPass : fsse_pkg::FmtInt32;
    end else begin
      status = fsse_pkg::StWidth;
    end
  end

  // Advance the whole pipe unless the output word is stuck.
  assign advance = !out_valid || out_ready;
  assign in_ready = advance;
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 3'b000;
    end else if (advance) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // Carry side data alongside the stages.
  always_ff @(posedge clk) begin
    if (advance) begin
      raw1 <= float_bits;
      raw2 <= raw1;
      row <= {row[1:0], row_end_in};
      st1 <= status;
      st2 <= st1;
      st3 <= st2;
    end
  end

  fsse_decode u_decode (
    .clk(clk), .advance(advance), .float_bits(float_bits), .dec(dec)
  );

  fsse_shift u_shift (
    .clk(clk), .advance(advance), .dec(dec), .mag(mag), .neg(neg), .big(big)
  );

  fsse_clamp u_clamp (
    .clk(clk), .advance(advance), .mag(mag), .neg(neg), .big(big), .raw(raw2),
    .fmt(fmt), .signed_fmt(sample_kind == fsse_pkg::KindSigned), .encoded(enc)
  );

  assign encode_status = st3;
  assign encoded_sample = (st3 == fsse_pkg::StOk) ? enc : 32'd0;
  assign row_end_out = row[2];

  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_err_zero, clk, rst, out_valid && encode_status != fsse_pkg::StOk,
    encoded_sample == 32'd0)
  `ASSERT_IMPL(a_ready_stall, clk, rst, out_valid && !out_ready, !in_ready)

endmodule

FILE: src/fsse_decode.sv
// Stage one: split the float and classify NaN/zero/huge.
// Depends on fsse_pkg.
module fsse_decode (
  input  logic                          clk,
  input  logic                          advance,
  input  logic [31:0]                   float_bits,
  output fsse_pkg::dec_t                dec
);

  logic [7:0] expo;
  logic       nan;
  fsse_pkg::dec_t dec_next;

  // Classify the exponent.
  always_comb begin
    expo = float_bits[30:23];
    nan = (expo == 8'hFF) && (float_bits[22:0] != 23'd0);
    dec_next.is_neg = float_bits[31];
    dec_next.is_zero = nan || (expo < 8'd127);
    dec_next.is_big = !nan && (expo >= 8'd159);
    dec_next.shift = 5'(expo - 8'd127);
    dec_next.mant = {1'b1, float_bits[22:0]};
  end

  // Hold while the pipe stalls.
  always_ff @(posedge clk) begin
    if (advance) begin
      dec <= dec_next;
    end
  end

endmodule

FILE: src/fsse_shift.sv
// Stage two: shift the mantissa to its integer magnitude (truncated).
// Depends on fsse_pkg.
module fsse_shift (
  input  logic           clk,
  input  logic           advance,
  input  fsse_pkg::dec_t dec,
  output logic [31:0]    mag,
  output logic           neg,
  output logic           big
);

  logic [54:0] wide;

  always_comb begin
    wide = {31'd0, dec.mant} << dec.shift;
  end

  // Keep the integer part; zero when below one.
  always_ff @(posedge clk) begin
    if (advance) begin
      mag <= dec.is_zero ? 32'd0 : wide[54:23];
      neg <= dec.is_neg && !dec.is_zero;
      big <= dec.is_big;
    end
  end

endmodule

FILE: src/fsse_clamp.sv
// Stage three: saturate to the target range and encode, or pass through.
// Depends on fsse_pkg.
module fsse_clamp (
  input  logic                  clk,
  input  logic                  advance,
  input  logic [31:0]           mag,
  input  logic                  neg,
  input  logic                  big,
  input  logic [31:0]           raw,
  input  fsse_pkg::fmt_t        fmt,
  input  logic                  signed_fmt,
  output logic [31:0]           encoded
);

  logic [31:0] pos_max;
  logic [31:0] neg_max;
  logic [32:0] lim;
  logic [31:0] val;
  logic [31:0] mask;

  // Pick range limits for the format.
  always_comb begin
    unique case (fmt)
      fsse_pkg::FmtInt8: mask = 32'h0000_00FF;
      fsse_pkg::FmtInt16: mask = 32'h0000_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    pos_max = signed_fmt ? (mask >> 1) : mask;
    neg_max = signed_fmt ? ((mask >> 1) + 32'd1) : 32'd0;
    lim = {1'b0, neg ? neg_max : pos_max};
    if (big || ({1'b0, mag} > lim)) begin
      val = lim[31:0];
    end else begin
      val = mag;
    end
    if (neg) begin
      val = 32'(-val);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      encoded <= (fmt == fsse_pkg::FmtPass) ? raw : (val & mask);
    end
  end

endmodule
